// ===== src/vrra_pkg.sv =====
// Package for the variable-length record ring allocator.
// Holds sizes, derived widths, codes, descriptor and RAM port types, FSM states.
// No dependencies.
`default_nettype none

package vrra_pkg;

    // Sizing of the byte pool, the descriptor ring and the longest record.
    localparam int unsigned POOL_BYTES     = 2097152;
    localparam int unsigned MAX_RECORDS    = 16384;
    localparam int unsigned MAX_RECORD_LEN = 1024;

    // A record with its terminator must always fit in the pool.
    localparam int unsigned CLAMP_LEN =
        (MAX_RECORD_LEN < POOL_BYTES - 1) ? MAX_RECORD_LEN : POOL_BYTES - 1;

    // Internal widths follow the sizes above.
    localparam int unsigned OFF_W  = $clog2(POOL_BYTES);
    localparam int unsigned WP_W   = $clog2(POOL_BYTES + 1);
    localparam int unsigned LEN_W  = $clog2(CLAMP_LEN + 1);
    localparam int unsigned SLOT_W = $clog2(MAX_RECORDS);
    localparam int unsigned CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int unsigned SEQ_W  = 32;

    // Fixed field widths of the request and response transactions.
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned RLEN_W      = 16;
    localparam int unsigned LVL_W       = 3;
    localparam int unsigned IDX_W       = 14;
    localparam int unsigned ECNT_OUT_W  = 15;
    localparam int unsigned OFF_OUT_W   = 21;
    localparam int unsigned LEN_OUT_W   = 11;
    localparam int unsigned TOT_OUT_W   = 15;
    localparam int unsigned BYTES_OUT_W = 22;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_APPEND = 2'd0;
    localparam t_kind KIND_CLEAR  = 2'd1;
    localparam t_kind KIND_LOOKUP = 2'd2;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [LVL_W-1:0] lvl;
    } t_desc;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        t_desc             data;
    } t_ram_wr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_OVL,
        S_APP,
        S_LOOK,
        S_RESULT
    } t_state;

    // Ring slot arithmetic; b is at most MAX_RECORDS for every meaningful use.
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(MAX_RECORDS)) begin
            s = s - (CNT_W + 1)'(MAX_RECORDS);
        end
        return SLOT_W'(s);
    endfunction

endpackage

`default_nettype wire

// ===== src/vrra_if.sv =====
// Request and response channel interfaces of the record ring allocator.
// Depends on vrra_pkg for the field widths.
`default_nettype none

interface vrra_req_if;
    logic                           valid;
    logic                           ready;
    logic [vrra_pkg::KIND_W-1:0]    kind;
    logic [vrra_pkg::RLEN_W-1:0]    record_length;
    logic [vrra_pkg::LVL_W-1:0]     record_level;
    logic [vrra_pkg::IDX_W-1:0]     lookup_index;

    modport source (output valid, output kind, output record_length,
                    output record_level, output lookup_index, input ready);
    modport sink   (input valid, input kind, input record_length,
                    input record_level, input lookup_index, output ready);
endinterface

interface vrra_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [vrra_pkg::ECNT_OUT_W-1:0]   evicted_count;
    logic                              hit;
    logic [vrra_pkg::SEQ_W-1:0]        entry_sequence;
    logic [vrra_pkg::OFF_OUT_W-1:0]    entry_offset;
    logic [vrra_pkg::LEN_OUT_W-1:0]    entry_length;
    logic [vrra_pkg::LVL_W-1:0]        entry_level;
    logic [vrra_pkg::SEQ_W-1:0]        oldest_sequence;
    logic [vrra_pkg::TOT_OUT_W-1:0]    record_total;
    logic [vrra_pkg::BYTES_OUT_W-1:0]  text_byte_total;

    modport source (output valid, output evicted_count, output hit,
                    output entry_sequence, output entry_offset, output entry_length,
                    output entry_level, output oldest_sequence, output record_total,
                    output text_byte_total, input ready);
    modport sink   (input valid, input evicted_count, input hit,
                    input entry_sequence, input entry_offset, input entry_length,
                    input entry_level, input oldest_sequence, input record_total,
                    input text_byte_total, output ready);
endinterface

`default_nettype wire

// ===== src/vrra_desc_ram.sv =====
// Descriptor memory: one write port, one read port, registered read data.
// Depends on vrra_pkg for the descriptor type and depth.
`default_nettype none

module vrra_desc_ram (
    input  wire logic                          i_clk,
    input  wire vrra_pkg::t_ram_wr             i_wr,
    input  wire logic [vrra_pkg::SLOT_W-1:0]   i_rd_addr,
    output vrra_pkg::t_desc                    o_rd_data
);

    vrra_pkg::t_desc r_mem [vrra_pkg::MAX_RECORDS];
    vrra_pkg::t_desc r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/variable_record_ring_allocator.sv =====
// Top level of the variable-length record ring allocator.
// Depends on vrra_pkg, vrra_req_if, vrra_rsp_if and vrra_desc_ram.
`default_nettype none

// The block keeps the bookkeeping of a byte pool that holds variable-length
// records and a circular table of record descriptors (offset, length, level)
// in one synchronous memory; the text bytes themselves live elsewhere. Each
// request transaction carries an append, a clear or a lookup, and each
// produces exactly one response transaction. One request is worked on at a
// time. An append whose record does not fit before the pool end first evicts
// every record that lies past the write point and wraps the write point;
// every append then evicts each record that overlaps the new span, writes
// the descriptor and reports. The eviction for a full table shares the last
// step of the overlap walk. A lookup reads the descriptor and reports; a
// clear resets the bookkeeping and, like an unused code, reports without
// touching the memory. The descriptor memory's read data arrive in the cycle
// after the address, and the eviction walk retires one descriptor per cycle,
// always reading the descriptor that will be the oldest in the next cycle.
// The finished result sits in an output register, so a new request is taken
// while the previous response still waits for its sink. The descriptor memory
// is not cleared after reset: only entries of held records are ever used, so the block is ready right after reset.

module variable_record_ring_allocator (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vrra_req_if.sink    i_req,
    vrra_rsp_if.source  o_rsp
);

    vrra_pkg::t_state                  r_state, n_state;

    // Latched request.
    logic [vrra_pkg::LEN_W-1:0]        r_len, n_len;
    logic [vrra_pkg::LVL_W-1:0]        r_lvl, n_lvl;
    logic [vrra_pkg::IDX_W-1:0]        r_idx, n_idx;

    // Ring bookkeeping.
    logic [vrra_pkg::SLOT_W-1:0]       r_oldest_slot, n_oldest_slot;
    logic [vrra_pkg::CNT_W-1:0]        r_held, n_held;
    logic [vrra_pkg::WP_W-1:0]         r_wp, n_wp;
    logic [vrra_pkg::WP_W-1:0]         r_bytes, n_bytes;
    logic [vrra_pkg::SEQ_W-1:0]        r_oldest_seq, n_oldest_seq;

    // Result of the current request.
    logic [vrra_pkg::CNT_W-1:0]        r_evict, n_evict;
    logic                              r_hit, n_hit;
    logic [vrra_pkg::SEQ_W-1:0]        r_seq, n_seq;
    logic [vrra_pkg::OFF_W-1:0]        r_off, n_off;
    logic [vrra_pkg::LEN_W-1:0]        r_elen, n_elen;
    logic [vrra_pkg::LVL_W-1:0]        r_elvl, n_elvl;

    // Output register.
    logic                              r_out_valid;
    logic [vrra_pkg::ECNT_OUT_W-1:0]   r_o_evict;
    logic                              r_o_hit;
    logic [vrra_pkg::SEQ_W-1:0]        r_o_seq;
    logic [vrra_pkg::OFF_OUT_W-1:0]    r_o_off;
    logic [vrra_pkg::LEN_OUT_W-1:0]    r_o_len;
    logic [vrra_pkg::LVL_W-1:0]        r_o_lvl;
    logic [vrra_pkg::SEQ_W-1:0]        r_o_oldest;
    logic [vrra_pkg::TOT_OUT_W-1:0]    r_o_total;
    logic [vrra_pkg::BYTES_OUT_W-1:0]  r_o_bytes;

    // Memory port.
    vrra_pkg::t_ram_wr                 w_wr;
    logic [vrra_pkg::SLOT_W-1:0]       w_rd_addr;
    vrra_pkg::t_desc                   w_rd;

    logic                              w_accept;
    logic [vrra_pkg::LEN_W-1:0]        w_in_len;
    logic                              w_in_wrap;
    logic [vrra_pkg::LEN_W:0]          w_need;
    logic [vrra_pkg::WP_W:0]           w_end;
    logic [vrra_pkg::WP_W:0]           w_d_end;
    logic                              w_have;
    logic                              w_drop_wrap;
    logic                              w_drop_ovl;
    logic                              w_full;
    logic                              w_drop;
    logic                              w_out_load;

    vrra_desc_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    assign i_req.ready = (r_state == vrra_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // Clamp the requested length and decide at accept time whether the
    // record would run past the pool end.
    assign w_in_len = (i_req.record_length > vrra_pkg::RLEN_W'(vrra_pkg::CLAMP_LEN))
                    ? vrra_pkg::LEN_W'(vrra_pkg::CLAMP_LEN)
                    : vrra_pkg::LEN_W'(i_req.record_length);
    assign w_in_wrap = ((vrra_pkg::WP_W + 1)'(r_wp) + (vrra_pkg::WP_W + 1)'(w_in_len)
                        + (vrra_pkg::WP_W + 1)'(1))
                       > (vrra_pkg::WP_W + 1)'(vrra_pkg::POOL_BYTES);

    // Span of the new record and of the oldest held record, whose descriptor
    // is always present on the memory read data during the eviction walk.
    assign w_need  = (vrra_pkg::LEN_W + 1)'(r_len) + (vrra_pkg::LEN_W + 1)'(1);
    assign w_end   = (vrra_pkg::WP_W + 1)'(r_wp) + (vrra_pkg::WP_W + 1)'(w_need);
    assign w_d_end = (vrra_pkg::WP_W + 1)'(w_rd.off) + (vrra_pkg::WP_W + 1)'(w_rd.len)
                   + (vrra_pkg::WP_W + 1)'(1);

    assign w_have      = (r_held != '0);
    assign w_drop_wrap = w_have && (vrra_pkg::WP_W'(w_rd.off) >= r_wp);
    assign w_drop_ovl  = w_have && ((vrra_pkg::WP_W + 1)'(w_rd.off) < w_end)
                               && (w_d_end > (vrra_pkg::WP_W + 1)'(r_wp));
    assign w_full      = (r_held == vrra_pkg::CNT_W'(vrra_pkg::MAX_RECORDS));
    assign w_drop      = ((r_state == vrra_pkg::S_WRAP) && w_drop_wrap)
                      || ((r_state == vrra_pkg::S_OVL) && (w_drop_ovl || w_full));

    assign w_out_load  = (r_state == vrra_pkg::S_RESULT) && (!r_out_valid || o_rsp.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vrra_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_req.kind)
                        vrra_pkg::KIND_APPEND: n_state = w_in_wrap ? vrra_pkg::S_WRAP
                                                                   : vrra_pkg::S_OVL;
                        vrra_pkg::KIND_LOOKUP: n_state = vrra_pkg::S_LOOK;
                        default:               n_state = vrra_pkg::S_RESULT;
                    endcase
                end
            end
            vrra_pkg::S_WRAP: begin
                if (!w_drop_wrap) begin
                    n_state = vrra_pkg::S_OVL;
                end
            end
            vrra_pkg::S_OVL: begin
                // A drop for a full table leaves room, so the walk ends here.
                if (!w_drop_ovl) begin
                    n_state = vrra_pkg::S_APP;
                end
            end
            vrra_pkg::S_APP:  n_state = vrra_pkg::S_RESULT;
            vrra_pkg::S_LOOK: n_state = vrra_pkg::S_RESULT;
            vrra_pkg::S_RESULT: begin
                if (w_out_load) begin
                    n_state = vrra_pkg::S_IDLE;
                end
            end
            default: n_state = vrra_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_len         = r_len;
        n_lvl         = r_lvl;
        n_idx         = r_idx;
        n_oldest_slot = r_oldest_slot;
        n_held        = r_held;
        n_wp          = r_wp;
        n_bytes       = r_bytes;
        n_oldest_seq  = r_oldest_seq;
        n_evict       = r_evict;
        n_hit         = r_hit;
        n_seq         = r_seq;
        n_off         = r_off;
        n_elen        = r_elen;
        n_elvl        = r_elvl;
        w_wr          = '0;

        unique case (r_state)
            vrra_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_len   = w_in_len;
                    n_lvl   = i_req.record_level;
                    n_idx   = i_req.lookup_index;
                    n_evict = '0;
                    n_hit   = 1'b0;
                    n_seq   = '0;
                    n_off   = '0;
                    n_elen  = '0;
                    n_elvl  = '0;
                    if (i_req.kind == vrra_pkg::KIND_CLEAR) begin
                        // Numbering continues past the dropped records.
                        n_oldest_seq  = r_oldest_seq + vrra_pkg::SEQ_W'(r_held);
                        n_oldest_slot = '0;
                        n_held        = '0;
                        n_wp          = '0;
                        n_bytes       = '0;
                    end
                end
            end
            vrra_pkg::S_WRAP: begin
                if (!w_drop_wrap) begin
                    n_wp = '0;
                end
            end
            vrra_pkg::S_APP: begin
                w_wr.we       = 1'b1;
                w_wr.addr     = vrra_pkg::slot_add(r_oldest_slot, r_held);
                w_wr.data.off = vrra_pkg::OFF_W'(r_wp);
                w_wr.data.len = r_len;
                w_wr.data.lvl = r_lvl;
                n_hit         = 1'b1;
                n_seq         = r_oldest_seq + vrra_pkg::SEQ_W'(r_held);
                n_off         = vrra_pkg::OFF_W'(r_wp);
                n_elen        = r_len;
                n_elvl        = r_lvl;
                n_wp          = r_wp + vrra_pkg::WP_W'(w_need);
                n_bytes       = r_bytes + vrra_pkg::WP_W'(r_len);
                n_held        = r_held + vrra_pkg::CNT_W'(1);
            end
            vrra_pkg::S_LOOK: begin
                if ((vrra_pkg::CNT_W + vrra_pkg::IDX_W)'(r_idx)
                    < (vrra_pkg::CNT_W + vrra_pkg::IDX_W)'(r_held)) begin
                    n_hit  = 1'b1;
                    n_seq  = r_oldest_seq + vrra_pkg::SEQ_W'(r_idx);
                    n_off  = w_rd.off;
                    n_elen = w_rd.len;
                    n_elvl = w_rd.lvl;
                end
            end
            default: begin
            end
        endcase

        // Retire the oldest record.
        if (w_drop) begin
            n_oldest_slot = vrra_pkg::slot_add(r_oldest_slot, vrra_pkg::CNT_W'(1));
            n_held        = r_held - vrra_pkg::CNT_W'(1);
            n_bytes       = r_bytes - vrra_pkg::WP_W'(w_rd.len);
            n_oldest_seq  = r_oldest_seq + vrra_pkg::SEQ_W'(1);
            n_evict       = r_evict + vrra_pkg::CNT_W'(1);
        end
    end

    // The memory always reads the descriptor that will be the oldest in the
    // next cycle, except when a lookup is accepted. The append write lands in
    // the slot of the oldest record only when the table was empty, and the
    // result cycle after it refreshes the read before anything uses it.
    always_comb begin
        if (w_accept && (i_req.kind == vrra_pkg::KIND_LOOKUP)) begin
            w_rd_addr = vrra_pkg::slot_add(r_oldest_slot, vrra_pkg::CNT_W'(i_req.lookup_index));
        end else begin
            w_rd_addr = n_oldest_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= vrra_pkg::S_IDLE;
            r_oldest_slot <= '0;
            r_held        <= '0;
            r_wp          <= '0;
            r_bytes       <= '0;
            r_oldest_seq  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_oldest_slot <= n_oldest_slot;
            r_held        <= n_held;
            r_wp          <= n_wp;
            r_bytes       <= n_bytes;
            r_oldest_seq  <= n_oldest_seq;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_lvl   <= n_lvl;
        r_idx   <= n_idx;
        r_evict <= n_evict;
        r_hit   <= n_hit;
        r_seq   <= n_seq;
        r_off   <= n_off;
        r_elen  <= n_elen;
        r_elvl  <= n_elvl;
        if (w_out_load) begin
            r_o_evict  <= vrra_pkg::ECNT_OUT_W'(r_evict);
            r_o_hit    <= r_hit;
            r_o_seq    <= r_seq;
            r_o_off    <= vrra_pkg::OFF_OUT_W'(r_off);
            r_o_len    <= vrra_pkg::LEN_OUT_W'(r_elen);
            r_o_lvl    <= r_elvl;
            r_o_oldest <= r_oldest_seq;
            r_o_total  <= vrra_pkg::TOT_OUT_W'(r_held);
            r_o_bytes  <= vrra_pkg::BYTES_OUT_W'(r_bytes);
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.evicted_count   = r_o_evict;
    assign o_rsp.hit             = r_o_hit;
    assign o_rsp.entry_sequence  = r_o_seq;
    assign o_rsp.entry_offset    = r_o_off;
    assign o_rsp.entry_length    = r_o_len;
    assign o_rsp.entry_level     = r_o_lvl;
    assign o_rsp.oldest_sequence = r_o_oldest;
    assign o_rsp.record_total    = r_o_total;
    assign o_rsp.text_byte_total = r_o_bytes;

endmodule

`default_nettype wire

// ===== src/vrra_checker.sv =====
// Port-level checks of the record ring allocator, bound to the top level.
// Depends on vrra_pkg and on the port list of variable_record_ring_allocator.
`default_nettype none

module vrra_port_props (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_rsp_valid,
    input wire logic                                 i_rsp_ready,
    input wire logic [vrra_pkg::ECNT_OUT_W-1:0]      i_evicted_count,
    input wire logic                                 i_hit,
    input wire logic [vrra_pkg::SEQ_W-1:0]           i_entry_sequence,
    input wire logic [vrra_pkg::OFF_OUT_W-1:0]       i_entry_offset,
    input wire logic [vrra_pkg::LEN_OUT_W-1:0]       i_entry_length,
    input wire logic [vrra_pkg::LVL_W-1:0]           i_entry_level,
    input wire logic [vrra_pkg::TOT_OUT_W-1:0]       i_record_total,
    input wire logic [vrra_pkg::BYTES_OUT_W-1:0]     i_text_byte_total
);

    // A stalled response keeps its content.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_entry_sequence)
            && $stable(i_record_total) && $stable(i_hit))
        else $error("response changed while stalled");

    // A miss, a clear or an unused code reports an all-zero record.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_hit |-> (i_entry_sequence == '0) && (i_entry_offset == '0)
            && (i_entry_length == '0) && (i_entry_level == '0))
        else $error("record fields set without a hit");

    // Only an append evicts, and an append always hits.
    a_evict_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_evicted_count != '0) |-> i_hit)
        else $error("eviction reported without a hit");

    // An empty table holds no text, and the table never overfills.
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_record_total <= vrra_pkg::TOT_OUT_W'(vrra_pkg::MAX_RECORDS))
            && ((i_record_total != '0) || (i_text_byte_total == '0)))
        else $error("record and byte totals disagree");

endmodule

bind variable_record_ring_allocator vrra_port_props u_port_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_evicted_count   (o_rsp.evicted_count),
    .i_hit             (o_rsp.hit),
    .i_entry_sequence  (o_rsp.entry_sequence),
    .i_entry_offset    (o_rsp.entry_offset),
    .i_entry_length    (o_rsp.entry_length),
    .i_entry_level     (o_rsp.entry_level),
    .i_record_total    (o_rsp.record_total),
    .i_text_byte_total (o_rsp.text_byte_total)
);

`default_nettype wire
